[hw/rtl/lkv_pkg.sv]
// Package for the LRU key/value cache: field widths, codes, state and flag types.
`timescale 1ns / 1ps

package lkv_pkg;

  // Default number of cells
  localparam int DEF_ENTRIES = 16;

  // Field widths
  localparam int KEY_W  = 32;
  localparam int VAL_W  = 31;
  localparam int RVAL_W = 32;
  localparam int CAP_W  = 5;

  // Capacity after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Read value returned on a miss and for every set
  localparam logic signed [RVAL_W-1:0] MISS_VALUE = -32'sd1;

  // Action codes
  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_SET = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_UPDATE,
    ST_DONE
  } state_t;

  // Recency update applied in the write-back sweep
  typedef enum logic {
    UPD_PROMOTE,
    UPD_INSERT
  } upd_mode_t;

  // Per-cell status from the compare unit
  typedef struct packed {
    logic match;
    logic older;
    logic wr_en;
  } cmp_flags_t;

endpackage

[hw/rtl/lkv_if.sv]
// Valid/ready channel interfaces for the request and result beats.
`timescale 1ns / 1ps

interface lkv_in_if import lkv_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    action;
  logic signed [KEY_W-1:0] key;
  logic [VAL_W-1:0]        write_value;

  modport source (output valid, action, key, write_value, input ready);
  modport sink   (input valid, action, key, write_value, output ready);
endinterface

interface lkv_out_if import lkv_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     found;
  logic signed [RVAL_W-1:0] read_value;
  logic                     evicted;
  logic signed [KEY_W-1:0]  evicted_key;

  modport source (output valid, found, read_value, evicted, evicted_key, input ready);
  modport sink   (input valid, found, read_value, evicted, evicted_key, output ready);
endinterface

[hw/rtl/lkv_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lkv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

[hw/rtl/lkv_cmp_unit.sv]
// Shared per-cell compare unit: key match, LRU compare and recency write-back word.
`timescale 1ns / 1ps

module lkv_cmp_unit import lkv_pkg::*; #(
  parameter int RANK_W = 4
) (
  input  logic                    ent_valid,
  input  logic [KEY_W-1:0]        ent_key,
  input  logic [VAL_W-1:0]        ent_val,
  input  logic [RANK_W-1:0]       ent_rank,
  input  logic [KEY_W-1:0]        q_key,
  input  logic [VAL_W-1:0]        q_val,
  input  upd_mode_t               mode,
  input  logic                    is_tgt,
  input  logic [RANK_W-1:0]       old_rank,
  input  logic                    best_f,
  input  logic [RANK_W-1:0]       best_rank,
  output cmp_flags_t              flags,
  output logic [KEY_W+VAL_W+RANK_W-1:0] wr_word
);

  logic age;

  // lookup and least-recent tracking
  assign flags.match = ent_valid && (ent_key == q_key);
  assign flags.older = ent_valid && (!best_f || (ent_rank > best_rank));

  // aging: every valid cell on insert, only the more recent ones on promote
  assign age = ent_valid && ((mode == UPD_INSERT) || (ent_rank < old_rank));
  assign flags.wr_en = is_tgt || age;

  // target cell becomes most recent with the new pair
  always_comb begin
    if (is_tgt) begin
      wr_word = {q_key, q_val, {RANK_W{1'b0}}};
    end else begin
      wr_word = {ent_key, ent_val, ent_rank + RANK_W'(1)};
    end
  end

endmodule

[hw/rtl/lru_key_value_cache.sv]
// Top level of the fully associative LRU key/value cache with its cell sequencer.
`timescale 1ns / 1ps

// Fully associative key/value cache with least-recently-used replacement over
// ENTRIES cells. One request is taken at a time. Cells are held in a single RAM
// (key, value, recency rank) and visited one per cycle through one shared compare
// unit: a get runs one lookup sweep, a decide step and a result load; a set runs
// the lookup sweep, decide, a read-modify-write sweep that ages the ranks and
// writes the new pair, then the result load. The sweep pace is set by the single
// RAM read port, one cell per cycle. The next request is accepted as soon as the
// result sits in the output register, even if it has not been taken. Valid bits
// are flip-flops cleared by reset, so there is no clearing pass. Capacity 0 acts
// as 1 and values above ENTRIES act as ENTRIES; lowering it below the fill level
// evicts one cell per later insert.
module lru_key_value_cache import lkv_pkg::*; #(
  parameter int ENTRIES = DEF_ENTRIES
) (
  input  logic             clk,
  input  logic             rst_n,
  lkv_in_if.sink           in_ch,
  lkv_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_data
);

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RANK_W = IDX_W;
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int EW     = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int WORD_W = KEY_W + VAL_W + RANK_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
  localparam logic [CNT_W-1:0] END_PTR  = CNT_W'(ENTRIES);

  // control state
  state_t             state_r, state_nxt;
  logic [CAP_W-1:0]   cap_r, cap_nxt;
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic               dq_vld_r, dq_vld_nxt;
  logic               hit_f_r, hit_f_nxt;
  logic               lru_f_r, lru_f_nxt;
  logic               free_f_r, free_f_nxt;
  logic               out_valid_r, out_valid_nxt;

  // payload state
  logic [IDX_W-1:0]   dq_idx_r, dq_idx_nxt;
  logic               q_act_r, q_act_nxt;
  logic [KEY_W-1:0]   q_key_r, q_key_nxt;
  logic [VAL_W-1:0]   q_val_r, q_val_nxt;
  logic [IDX_W-1:0]   hit_idx_r, hit_idx_nxt;
  logic [RANK_W-1:0]  hit_rank_r, hit_rank_nxt;
  logic [VAL_W-1:0]   hit_val_r, hit_val_nxt;
  logic [IDX_W-1:0]   lru_idx_r, lru_idx_nxt;
  logic [RANK_W-1:0]  lru_rank_r, lru_rank_nxt;
  logic [KEY_W-1:0]   lru_key_r, lru_key_nxt;
  logic [IDX_W-1:0]   free_idx_r, free_idx_nxt;
  logic [IDX_W-1:0]   tgt_r, tgt_nxt;
  upd_mode_t          mode_r, mode_nxt;
  logic               res_found_r, res_found_nxt;
  logic [RVAL_W-1:0]  res_rval_r, res_rval_nxt;
  logic               res_ev_r, res_ev_nxt;
  logic [KEY_W-1:0]   res_evkey_r, res_evkey_nxt;
  logic               out_found_r, out_found_nxt;
  logic [RVAL_W-1:0]  out_rval_r, out_rval_nxt;
  logic               out_ev_r, out_ev_nxt;
  logic [KEY_W-1:0]   out_evkey_r, out_evkey_nxt;

  // datapath
  logic               ram_we;
  logic [IDX_W-1:0]   ram_raddr;
  logic [WORD_W-1:0]  ram_rdata;
  logic [WORD_W-1:0]  wr_word;
  logic [KEY_W-1:0]   ent_key;
  logic [VAL_W-1:0]   ent_val;
  logic [RANK_W-1:0]  ent_rank;
  logic               ent_valid;
  cmp_flags_t         flags;
  logic               rd_issue;
  logic               sweep_last;
  logic [EW-1:0]      cap_ext;
  logic [EW-1:0]      eff_cap;
  logic               evict;
  logic [IDX_W-1:0]   ins_idx;

  // cell storage
  lkv_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ENTRIES)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (dq_idx_r),
    .wdata (wr_word),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // returned cell fields
  assign ent_key   = ram_rdata[WORD_W-1 -: KEY_W];
  assign ent_val   = ram_rdata[RANK_W +: VAL_W];
  assign ent_rank  = ram_rdata[RANK_W-1:0];
  assign ent_valid = valid_r[dq_idx_r];

  // shared compare unit
  lkv_cmp_unit #(
    .RANK_W (RANK_W)
  ) u_cmp (
    .ent_valid (ent_valid),
    .ent_key   (ent_key),
    .ent_val   (ent_val),
    .ent_rank  (ent_rank),
    .q_key     (q_key_r),
    .q_val     (q_val_r),
    .mode      (mode_r),
    .is_tgt    (dq_idx_r == tgt_r),
    .old_rank  (hit_rank_r),
    .best_f    (lru_f_r),
    .best_rank (lru_rank_r),
    .flags     (flags),
    .wr_word   (wr_word)
  );

  // sweep read issue
  assign rd_issue   = ((state_r == ST_SCAN) || (state_r == ST_UPDATE)) && (rd_ptr_r != END_PTR);
  assign ram_raddr  = rd_ptr_r[IDX_W-1:0];
  assign sweep_last = dq_vld_r && (dq_idx_r == LAST_IDX);
  assign ram_we     = (state_r == ST_UPDATE) && dq_vld_r && flags.wr_en;

  // effective capacity, clamped to 1..ENTRIES
  assign cap_ext = EW'(cap_r);
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = EW'(1);
    end else if (cap_ext > EW'(ENTRIES)) begin
      eff_cap = EW'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign evict   = (EW'(count_r) >= eff_cap) && lru_f_r;
  assign ins_idx = evict ? lru_idx_r : free_idx_r;

  // handshake ports
  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.found       = out_found_r;
  assign out_ch.read_value  = out_rval_r;
  assign out_ch.evicted     = out_ev_r;
  assign out_ch.evicted_key = out_evkey_r;

  // sequencer: next state and datapath updates
  always_comb begin
    state_nxt     = state_r;
    cap_nxt       = cfg_we ? cfg_data : cap_r;
    valid_nxt     = valid_r;
    count_nxt     = count_r;
    rd_ptr_nxt    = rd_issue ? rd_ptr_r + CNT_W'(1) : rd_ptr_r;
    dq_vld_nxt    = rd_issue;
    dq_idx_nxt    = rd_ptr_r[IDX_W-1:0];
    hit_f_nxt     = hit_f_r;
    lru_f_nxt     = lru_f_r;
    free_f_nxt    = free_f_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    q_act_nxt     = q_act_r;
    q_key_nxt     = q_key_r;
    q_val_nxt     = q_val_r;
    hit_idx_nxt   = hit_idx_r;
    hit_rank_nxt  = hit_rank_r;
    hit_val_nxt   = hit_val_r;
    lru_idx_nxt   = lru_idx_r;
    lru_rank_nxt  = lru_rank_r;
    lru_key_nxt   = lru_key_r;
    free_idx_nxt  = free_idx_r;
    tgt_nxt       = tgt_r;
    mode_nxt      = mode_r;
    res_found_nxt = res_found_r;
    res_rval_nxt  = res_rval_r;
    res_ev_nxt    = res_ev_r;
    res_evkey_nxt = res_evkey_r;
    out_found_nxt = out_found_r;
    out_rval_nxt  = out_rval_r;
    out_ev_nxt    = out_ev_r;
    out_evkey_nxt = out_evkey_r;

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          q_act_nxt  = in_ch.action;
          q_key_nxt  = in_ch.key;
          q_val_nxt  = in_ch.write_value;
          hit_f_nxt  = 1'b0;
          lru_f_nxt  = 1'b0;
          free_f_nxt = 1'b0;
          rd_ptr_nxt = '0;
          state_nxt  = ST_SCAN;
        end
      end

      // lookup sweep: hit, least recent cell, first free cell
      ST_SCAN: begin
        if (dq_vld_r) begin
          if (flags.match && !hit_f_r) begin
            hit_f_nxt    = 1'b1;
            hit_idx_nxt  = dq_idx_r;
            hit_rank_nxt = ent_rank;
            hit_val_nxt  = ent_val;
          end
          if (flags.older) begin
            lru_f_nxt    = 1'b1;
            lru_idx_nxt  = dq_idx_r;
            lru_rank_nxt = ent_rank;
            lru_key_nxt  = ent_key;
          end
          if (!ent_valid && !free_f_r) begin
            free_f_nxt   = 1'b1;
            free_idx_nxt = dq_idx_r;
          end
        end
        if (sweep_last) begin
          state_nxt = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        res_found_nxt = hit_f_r;
        res_rval_nxt  = MISS_VALUE;
        res_ev_nxt    = 1'b0;
        res_evkey_nxt = '0;
        rd_ptr_nxt    = '0;
        if (q_act_r == ACT_GET) begin
          if (hit_f_r) begin
            res_rval_nxt = {1'b0, hit_val_r};
          end
          state_nxt = ST_DONE;
        end else if (hit_f_r) begin
          // update in place and promote
          tgt_nxt   = hit_idx_r;
          mode_nxt  = UPD_PROMOTE;
          state_nxt = ST_UPDATE;
        end else begin
          // insert, reusing the least recent cell when full
          tgt_nxt            = ins_idx;
          mode_nxt           = UPD_INSERT;
          valid_nxt[ins_idx] = 1'b1;
          if (evict) begin
            res_ev_nxt    = 1'b1;
            res_evkey_nxt = lru_key_r;
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
          state_nxt = ST_UPDATE;
        end
      end

      // write-back sweep: age ranks, write the target cell
      ST_UPDATE: begin
        if (sweep_last) begin
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_rval_nxt  = res_rval_r;
          out_ev_nxt    = res_ev_r;
          out_evkey_nxt = res_evkey_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= CAP_RESET;
      valid_r     <= '0;
      count_r     <= '0;
      rd_ptr_r    <= '0;
      dq_vld_r    <= 1'b0;
      hit_f_r     <= 1'b0;
      lru_f_r     <= 1'b0;
      free_f_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cap_r       <= cap_nxt;
      valid_r     <= valid_nxt;
      count_r     <= count_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      dq_vld_r    <= dq_vld_nxt;
      hit_f_r     <= hit_f_nxt;
      lru_f_r     <= lru_f_nxt;
      free_f_r    <= free_f_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    dq_idx_r    <= dq_idx_nxt;
    q_act_r     <= q_act_nxt;
    q_key_r     <= q_key_nxt;
    q_val_r     <= q_val_nxt;
    hit_idx_r   <= hit_idx_nxt;
    hit_rank_r  <= hit_rank_nxt;
    hit_val_r   <= hit_val_nxt;
    lru_idx_r   <= lru_idx_nxt;
    lru_rank_r  <= lru_rank_nxt;
    lru_key_r   <= lru_key_nxt;
    free_idx_r  <= free_idx_nxt;
    tgt_r       <= tgt_nxt;
    mode_r      <= mode_nxt;
    res_found_r <= res_found_nxt;
    res_rval_r  <= res_rval_nxt;
    res_ev_r    <= res_ev_nxt;
    res_evkey_r <= res_evkey_nxt;
    out_found_r <= out_found_nxt;
    out_rval_r  <= out_rval_nxt;
    out_ev_r    <= out_ev_nxt;
    out_evkey_r <= out_evkey_nxt;
  end

  // fill count tracks the valid bits
  a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(count_r))
    else $error("fill count differs from number of valid cells");

  // a decision never lowers the fill count
  a_count_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DECIDE) |=> (count_r >= $past(count_r)))
    else $error("fill count dropped on a request");

  // an eviction only comes from a set that missed
  a_evict_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.evicted) |-> (!out_ch.found && (out_ch.read_value == MISS_VALUE)))
    else $error("eviction reported on a hit or a get");

  // an accepted beat starts a clean lookup sweep
  a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> ((state_r == ST_SCAN) && !hit_f_r && !lru_f_r))
    else $error("lookup sweep did not start clean");

endmodule

[test/lkv_checker.sv]
// Result checker for the LRU key/value cache: tracks cache contents and checks each result beat.
`timescale 1ns / 1ps

module lkv_checker import lkv_pkg::*; #(
  parameter int ENTRIES = DEF_ENTRIES
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic                     in_action,
  input  logic signed [KEY_W-1:0]  in_key,
  input  logic [VAL_W-1:0]         in_write_value,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic                     out_found,
  input  logic signed [RVAL_W-1:0] out_read_value,
  input  logic                     out_evicted,
  input  logic signed [KEY_W-1:0]  out_evicted_key,
  input  logic                     cfg_we,
  input  logic [CAP_W-1:0]         cfg_data,
  output int                       mismatches,
  output int                       outstanding
);

  typedef struct packed {
    logic                     found;
    logic signed [RVAL_W-1:0] read_value;
    logic                     evicted;
    logic signed [KEY_W-1:0]  evicted_key;
  } cache_reply_t;

  // Shadow copy of the cache contents; age 0 is the most recent cell
  logic [KEY_W-1:0] cell_key  [ENTRIES];
  logic [VAL_W-1:0] cell_val  [ENTRIES];
  bit               cell_used [ENTRIES];
  int unsigned      cell_age  [ENTRIES];
  int unsigned      fill;
  logic [CAP_W-1:0] capacity;
  cache_reply_t     reply_q[$];

  // Capacity 0 behaves as 1, anything above the cell count as the cell count
  function automatic int unsigned usable_cells();
    if (capacity == 0) return 1;
    if (capacity > ENTRIES) return ENTRIES;
    return 32'(capacity);
  endfunction

  // Apply one request to the shadow cache and return the reply it must produce
  function automatic cache_reply_t serve_request(input logic act, input logic [KEY_W-1:0] k,
                                                 input logic [VAL_W-1:0] v);
    cache_reply_t r;
    int           i;
    int           hit;
    int           slot;
    int unsigned  oldest;
    r.found       = 1'b0;
    r.read_value  = MISS_VALUE;
    r.evicted     = 1'b0;
    r.evicted_key = '0;
    hit = -1;
    for (i = 0; i < ENTRIES; i++) begin
      if (hit < 0 && cell_used[i] && cell_key[i] == k) hit = i;
    end
    if (hit >= 0) r.found = 1'b1;

    if (act == ACT_GET) begin
      if (hit >= 0) r.read_value = {1'b0, cell_val[hit]};
    end else if (hit >= 0) begin
      // update in place, then make the cell most recent
      cell_val[hit] = v;
      for (i = 0; i < ENTRIES; i++) begin
        if (i != hit && cell_used[i] && cell_age[i] < cell_age[hit]) cell_age[i]++;
      end
      cell_age[hit] = 0;
    end else begin
      // new key: evict the oldest cell when full, else take the first free cell
      slot = -1;
      if (fill >= usable_cells()) begin
        oldest = 0;
        for (i = 0; i < ENTRIES; i++) begin
          if (cell_used[i] && (slot < 0 || cell_age[i] > oldest)) begin
            slot   = i;
            oldest = cell_age[i];
          end
        end
        if (slot >= 0) begin
          r.evicted       = 1'b1;
          r.evicted_key   = cell_key[slot];
          cell_used[slot] = 1'b0;
          fill--;
        end
      end
      if (slot < 0) begin
        for (i = 0; i < ENTRIES; i++) begin
          if (slot < 0 && !cell_used[i]) slot = i;
        end
      end
      if (slot >= 0) begin
        for (i = 0; i < ENTRIES; i++) begin
          if (cell_used[i]) cell_age[i]++;
        end
        cell_key[slot]  = k;
        cell_val[slot]  = v;
        cell_used[slot] = 1'b1;
        cell_age[slot]  = 0;
        fill++;
      end
    end
    return r;
  endfunction

  // Result beats are checked before the request beat of the same edge is queued
  always @(posedge clk) begin : watch
    cache_reply_t want;
    int           i;
    if (!rst_n) begin
      for (i = 0; i < ENTRIES; i++) begin
        cell_used[i] = 1'b0;
        cell_age[i]  = 0;
      end
      fill     = 0;
      capacity = CAP_RESET;
      reply_q.delete();
      outstanding = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (reply_q.size() == 0) begin
          $error("result beat with no request outstanding");
          mismatches++;
        end else begin
          want = reply_q.pop_front();
          if (want.found !== out_found) begin
            $error("found: expected %0d, got %0d", want.found, out_found);
            mismatches++;
          end
          if (want.read_value !== out_read_value) begin
            $error("read_value: expected %0d, got %0d", want.read_value, out_read_value);
            mismatches++;
          end
          if (want.evicted !== out_evicted) begin
            $error("evicted: expected %0d, got %0d", want.evicted, out_evicted);
            mismatches++;
          end
          if (want.evicted_key !== out_evicted_key) begin
            $error("evicted_key: expected %0d, got %0d", want.evicted_key, out_evicted_key);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        reply_q.push_back(serve_request(in_action, in_key, in_write_value));
      end
      if (cfg_we) capacity = cfg_data;
      outstanding = reply_q.size();
    end
  end

endmodule

[test/tb.sv]
// Testbench top for the LRU key/value cache: clock, reset, request traffic and verdict.
`timescale 1ns / 1ps

module tb;
  import lkv_pkg::*;

  localparam int ENTRIES     = DEF_ENTRIES;
  localparam int POOL        = ENTRIES + 4;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 210;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 3000;

  // Small capacities first while the cache is still filling, then full, then lowered, then oversized
  localparam logic [CAP_W-1:0] PHASE_CAPS [PHASES] =
    '{5'd2, 5'd5, 5'd9, 5'd16, 5'd17, 5'd3, 5'd1, 5'd31};

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_data;
  int               mismatches;
  int               outstanding;
  int               quiet_cycles = 0;
  bit               steady = 1'b0;
  bit               hold_req = 1'b0;
  int               pool_span = POOL;
  logic [KEY_W-1:0] key_pool [POOL];

  lkv_in_if  in_ch ();
  lkv_out_if out_ch ();

  lru_key_value_cache #(.ENTRIES(ENTRIES)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  lkv_checker #(.ENTRIES(ENTRIES)) lkv_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_action       (in_ch.action),
    .in_key          (in_ch.key),
    .in_write_value  (in_ch.write_value),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_found       (out_ch.found),
    .out_read_value  (out_ch.read_value),
    .out_evicted     (out_ch.evicted),
    .out_evicted_key (out_ch.evicted_key),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .outstanding     (outstanding)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog: ends the run when no beat moves on either channel for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random back-pressure, plus one long hold-off on request
  initial begin : result_sink
    bit held;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ch.ready <= rst_n && (steady || $urandom_range(99) >= 16);
    end
  end

  // Offer one request beat, with random idle cycles ahead of it, until accepted
  task automatic send_request(input logic act, input logic [KEY_W-1:0] k,
                              input logic [VAL_W-1:0] v);
    while (!steady && $urandom_range(99) < 16) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.action      <= act;
    in_ch.key         <= k;
    in_ch.write_value <= v;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  // Capacity is only changed once every result has been taken
  task automatic set_capacity(input logic [CAP_W-1:0] c);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= c;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly keys from a pool sized to the capacity so hits are common
  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(99) < 75) return key_pool[$urandom_range(pool_span - 1)];
    return $urandom();
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    return VAL_W'($urandom());
  endfunction

  initial begin : stimulus
    int          ph;
    int          n;
    int unsigned usable;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.action      <= ACT_GET;
    in_ch.key         <= '0;
    in_ch.write_value <= '0;
    cfg_we            <= 1'b0;
    cfg_data          <= CAP_RESET;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'hffff_ffff;
    key_pool[3] = 32'h0000_0000;
    key_pool[4] = 32'h0000_0001;
    for (n = 5; n < POOL; n++) key_pool[n] = $urandom();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // single-cell cache: miss on empty, replace, update in place
    set_capacity(5'd1);
    send_request(ACT_GET, 32'h8000_0000, 31'h7fff_ffff);
    send_request(ACT_SET, 32'h8000_0000, 31'h7fff_ffff);
    send_request(ACT_GET, 32'h8000_0000, 31'h7fff_ffff);
    send_request(ACT_SET, 32'h7fff_ffff, 31'h0);
    send_request(ACT_GET, 32'h7fff_ffff, 31'h1);
    send_request(ACT_SET, 32'h7fff_ffff, 31'h1);
    send_request(ACT_GET, 32'h8000_0000, 31'h0);

    // zero capacity acts as one
    set_capacity(5'd0);
    send_request(ACT_SET, 32'hffff_ffff, 31'h2);
    send_request(ACT_SET, 32'h0000_0000, 31'h3);

    // oversized capacity acts as the full cell count; update of the oldest cell
    set_capacity(5'd31);
    for (n = 1; n <= 5; n++) send_request(ACT_SET, KEY_W'(n), VAL_W'(n * 11));
    send_request(ACT_SET, 32'h0000_0000, 31'h7fff_ffff);
    send_request(ACT_GET, 32'h0000_0003, 31'h0);
    send_request(ACT_GET, 32'h0000_0000, 31'h0);
    send_request(ACT_SET, 32'h0000_0006, 31'h5555_5555);

    // random phases over a range of capacities
    for (ph = 0; ph < PHASES; ph++) begin
      set_capacity(PHASE_CAPS[ph]);
      usable = (PHASE_CAPS[ph] == 0) ? 1 :
               (PHASE_CAPS[ph] > ENTRIES) ? ENTRIES : int'(PHASE_CAPS[ph]);
      pool_span = int'(usable) + 4;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        steady = (ph == 1 && n < 120);
        if (ph == 3 && n == 40) hold_req = 1'b1;
        if ($urandom_range(99) < 55) send_request(ACT_SET, pick_key(), pick_value());
        else send_request(ACT_GET, pick_key(), pick_value());
      end
    end
    steady = 1'b0;

    // drain, then give stray results time to show up
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (2 * ENTRIES + 8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
